@@ src/s5rp_pkg.sv @@
// s5rp_pkg: shared types and constants of the SOCKS5 request parser.
// No dependencies; imported by every module in src.
`timescale 1ns / 1ps

package s5rp_pkg;

  // Parse states, one-hot
  typedef enum logic [9:0] {
    ST_VERSION = 10'b00_0000_0001,
    ST_CMD     = 10'b00_0000_0010,
    ST_RSV     = 10'b00_0000_0100,
    ST_ATYP    = 10'b00_0000_1000,
    ST_DOMLEN  = 10'b00_0001_0000,
    ST_ADDR    = 10'b00_0010_0000,
    ST_PORT_HI = 10'b00_0100_0000,
    ST_PORT_LO = 10'b00_1000_0000,
    ST_DONE    = 10'b01_0000_0000,
    ST_ERROR   = 10'b10_0000_0000
  } s5rp_state_e;

  // Event codes reported with each word
  localparam logic [3:0] EV_VERSION = 4'd0;
  localparam logic [3:0] EV_CMD     = 4'd1;
  localparam logic [3:0] EV_RSV     = 4'd2;
  localparam logic [3:0] EV_ATYP    = 4'd3;
  localparam logic [3:0] EV_DOMLEN  = 4'd4;
  localparam logic [3:0] EV_ADDR    = 4'd5;
  localparam logic [3:0] EV_PORT_HI = 4'd6;
  localparam logic [3:0] EV_PORT_LO = 4'd7;
  localparam logic [3:0] EV_DONE    = 4'd8;
  localparam logic [3:0] EV_ERROR   = 4'd9;

  // Protocol byte values
  localparam logic [7:0] VERSION_BYTE = 8'd5;
  localparam logic [7:0] RSV_BYTE     = 8'd0;
  localparam logic [7:0] CMD_CONNECT  = 8'd1;
  localparam logic [7:0] CMD_UDP      = 8'd3;
  localparam logic [7:0] ATYP_IPV4    = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN  = 8'd3;
  localparam logic [7:0] ATYP_IPV6    = 8'd4;
  localparam logic [7:0] IPV4_LEN     = 8'd4;
  localparam logic [7:0] IPV6_LEN     = 8'd16;

  // One result word
  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  addr_index;
    logic [1:0]  command;
    logic [2:0]  addr_type;
    logic [7:0]  addr_length;
    logic [15:0] dest_port;
  } s5rp_res_t;

  // Address store write request
  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    logic [7:0] data;
  } s5rp_wr_t;

endpackage

@@ src/s5rp_addr_store.sv @@
// s5rp_addr_store: synchronous memory holding the destination address bytes.
// Depends on s5rp_pkg for the write request type.
`timescale 1ns / 1ps

module s5rp_addr_store
  import s5rp_pkg::*;
#(
  parameter int ADDR_DEPTH = 256
) (
  input  logic     clk_i,
  input  s5rp_wr_t wr_i
);

  localparam int AW = $clog2(ADDR_DEPTH);

  logic [7:0] mem [ADDR_DEPTH];
  logic       in_range;

  // Drop writes past the end of the store
  assign in_range = {1'b0, wr_i.idx} < 9'(ADDR_DEPTH);

  // Write one address byte
  always_ff @(posedge clk_i) begin
    if (wr_i.en && in_range) begin
      mem[wr_i.idx[AW-1:0]] <= wr_i.data;
    end
  end

endmodule

@@ src/s5rp_fsm.sv @@
// s5rp_fsm: parse state machine and request field registers.
// Depends on s5rp_pkg; produces one result per word and one store write per address byte.
`timescale 1ns / 1ps

module s5rp_fsm
  import s5rp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output s5rp_res_t   res_o,
  output s5rp_wr_t    wr_o,
  output s5rp_state_e state_o
);

  s5rp_state_e state_q, state_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [2:0]  atyp_q, atyp_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] port_q, port_d;
  logic [3:0]  ev;
  logic [7:0]  idx;

  // Decode the next state and the result of this word
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    atyp_d    = atyp_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    port_d    = port_q;
    ev        = EV_ERROR;
    idx       = 8'd0;
    wr_o.en   = 1'b0;
    wr_o.idx  = cnt_q;
    wr_o.data = byte_i;
    unique case (state_q)
      ST_VERSION: begin
        if (byte_i == VERSION_BYTE) begin
          ev      = EV_VERSION;
          state_d = ST_CMD;
        end else begin
          state_d = ST_ERROR;
        end
      end
      ST_CMD: begin
        if (byte_i >= CMD_CONNECT && byte_i <= CMD_UDP) begin
          ev      = EV_CMD;
          cmd_d   = byte_i[1:0];
          state_d = ST_RSV;
        end else begin
          state_d = ST_ERROR;
        end
      end
      ST_RSV: begin
        if (byte_i == RSV_BYTE) begin
          ev      = EV_RSV;
          state_d = ST_ATYP;
        end else begin
          state_d = ST_ERROR;
        end
      end
      ST_ATYP: begin
        priority if (byte_i == ATYP_IPV4) begin
          ev      = EV_ATYP;
          atyp_d  = byte_i[2:0];
          len_d   = IPV4_LEN;
          state_d = ST_ADDR;
        end else if (byte_i == ATYP_DOMAIN) begin
          ev      = EV_ATYP;
          atyp_d  = byte_i[2:0];
          state_d = ST_DOMLEN;
        end else if (byte_i == ATYP_IPV6) begin
          ev      = EV_ATYP;
          atyp_d  = byte_i[2:0];
          len_d   = IPV6_LEN;
          state_d = ST_ADDR;
        end else begin
          state_d = ST_ERROR;
        end
      end
      ST_DOMLEN: begin
        ev      = EV_DOMLEN;
        len_d   = byte_i;
        state_d = ST_ADDR;
      end
      ST_ADDR: begin
        // Store the byte, then compare the advanced count
        ev      = EV_ADDR;
        idx     = cnt_q;
        wr_o.en = 1'b1;
        cnt_d   = cnt_q + 8'd1;
        if (cnt_d >= len_q) begin
          ev      = EV_PORT_HI;
          state_d = ST_PORT_HI;
        end
      end
      ST_PORT_HI: begin
        ev      = EV_PORT_HI;
        port_d  = {port_q[7:0], byte_i};
        state_d = ST_PORT_LO;
      end
      ST_PORT_LO: begin
        ev      = EV_PORT_LO;
        port_d  = {port_q[7:0], byte_i};
        state_d = ST_DONE;
      end
      ST_DONE: begin
        ev = EV_DONE;
      end
      default: begin
        ev      = EV_ERROR;
        state_d = ST_ERROR;
      end
    endcase
    wr_o.en = wr_o.en && step_i;
  end

  // Fields after the step
  assign res_o.event_res   = ev;
  assign res_o.data_byte   = byte_i;
  assign res_o.addr_index  = idx;
  assign res_o.command     = cmd_d;
  assign res_o.addr_type   = atyp_d;
  assign res_o.addr_length = len_d;
  assign res_o.dest_port   = port_d;
  assign state_o           = state_q;

  // Advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_VERSION;
      cmd_q   <= 2'd0;
      atyp_q  <= 3'd0;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
      port_q  <= 16'd0;
    end else if (step_i) begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      atyp_q  <= atyp_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      port_q  <= port_d;
    end
  end

endmodule

@@ src/socks5_request_parser_core.sv @@
// socks5_request_parser_core: top level of the SOCKS5 request parser.
// Depends on s5rp_pkg, s5rp_fsm and s5rp_addr_store.
//
//   channel | signals                                     | direction
//   --------+---------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, rx_byte_i           | into block
//   out     | out_valid_o, out_stall_i, event_res_o, ...  | out of block
//
// One word per cycle unless the output side stalls: each accepted byte yields its
// result word in the next cycle from the output register. The state update and the
// address store write complete in the accepting cycle, so bytes follow back to back.
// Reset clears the parse state and the field registers; the store is not cleared.
// Input stalls only while a result is held and the output side stalls.
`timescale 1ns / 1ps

module socks5_request_parser_core
  import s5rp_pkg::*;
#(
  parameter int ADDR_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_res_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  addr_index_o,
  output logic [1:0]  command_o,
  output logic [2:0]  addr_type_o,
  output logic [7:0]  addr_length_o,
  output logic [15:0] dest_port_o
);

  logic        in_acc;
  logic        out_valid_q;
  s5rp_res_t   res;
  s5rp_res_t   res_q;
  s5rp_wr_t    wr;
  s5rp_state_e state;

  // Take a word unless a held result is stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  s5rp_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_acc),
    .byte_i  (rx_byte_i),
    .res_o   (res),
    .wr_o    (wr),
    .state_o (state)
  );

  s5rp_addr_store #(
    .ADDR_DEPTH (ADDR_DEPTH)
  ) u_store (
    .clk_i (clk_i),
    .wr_i  (wr)
  );

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = res_q.event_res;
  assign data_byte_o   = res_q.data_byte;
  assign addr_index_o  = res_q.addr_index;
  assign command_o     = res_q.command;
  assign addr_type_o   = res_q.addr_type;
  assign addr_length_o = res_q.addr_length;
  assign dest_port_o   = res_q.dest_port;

  // Every accepted word shows up at the output next cycle
  a_acc_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted word not presented");

  // Error state is sticky
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state == ST_ERROR |=> state == ST_ERROR)
    else $error("left error state");

  // Nonzero address index only for address events, the last address byte's EV_PORT_HI included
  a_idx_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && addr_index_o != 8'd0 |->
      event_res_o == EV_ADDR || event_res_o == EV_PORT_HI)
    else $error("address index on non-address event");

  // Store writes happen only in the address state
  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> in_acc && state == ST_ADDR)
    else $error("store write outside address state");

endmodule

@@ sim/socks5_request_parser_core_tb.sv @@
// socks5_request_parser_core_tb: self-checking testbench of the SOCKS5 request parser.
// Depends on s5rp_pkg and socks5_request_parser_core; drives one request stream
// and compares every result word against a cycle-free parse predictor.
`timescale 1ns / 1ps

module socks5_request_parser_core_tb;
  import s5rp_pkg::*;

  localparam int TARGET_ITEMS = 1550;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [7:0] data;
    logic       drain;
  } rx_item_t;

  // Block ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i   = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  event_res_o;
  logic [7:0]  data_byte_o;
  logic [7:0]  addr_index_o;
  logic [1:0]  command_o;
  logic [2:0]  addr_type_o;
  logic [7:0]  addr_length_o;
  logic [15:0] dest_port_o;

  // Stimulus and scoreboard
  rx_item_t    rx_items[$];
  s5rp_res_t   predicted_words[$];
  int          n_items     = 0;
  int          sent_cnt    = 0;
  int          got_cnt     = 0;
  int          mismatch_cnt = 0;
  int          idle_cycles = 0;

  // Driver scratch
  int          drv_idx     = 0;
  logic        drv_valid;
  int          drv_sent;

  // Monitor scratch
  s5rp_res_t   mon_exp;
  s5rp_res_t   mon_act;

  // Predictor state, reset values
  s5rp_state_e psr_state = ST_VERSION;
  logic [1:0]  psr_cmd   = 2'd0;
  logic [2:0]  psr_atyp  = 3'd0;
  logic [7:0]  psr_len   = 8'd0;
  logic [7:0]  psr_cnt   = 8'd0;
  logic [15:0] psr_port  = 16'd0;

  socks5_request_parser_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .data_byte_o   (data_byte_o),
    .addr_index_o  (addr_index_o),
    .command_o     (command_o),
    .addr_type_o   (addr_type_o),
    .addr_length_o (addr_length_o),
    .dest_port_o   (dest_port_o)
  );

  always #5 clk_i = ~clk_i;

  // Idle percentage per phase: receiver-heavy, then sender-heavy, then none
  function automatic int idle_pct(input int count, input bit sender);
    if (count < n_items / 3) return sender ? 31 : 76;
    if (count < (2 * n_items) / 3) return sender ? 76 : 31;
    return 0;
  endfunction

  // Advance the parse by one byte and return the word it reports
  function automatic s5rp_res_t parse_byte(input logic [7:0] b);
    s5rp_res_t r;
    r.event_res  = EV_ERROR;
    r.addr_index = 8'd0;
    case (psr_state)
      ST_VERSION: begin
        if (b == VERSION_BYTE) begin
          r.event_res = EV_VERSION;
          psr_state   = ST_CMD;
        end else psr_state = ST_ERROR;
      end
      ST_CMD: begin
        if (b >= CMD_CONNECT && b <= CMD_UDP) begin
          r.event_res = EV_CMD;
          psr_cmd     = b[1:0];
          psr_state   = ST_RSV;
        end else psr_state = ST_ERROR;
      end
      ST_RSV: begin
        if (b == RSV_BYTE) begin
          r.event_res = EV_RSV;
          psr_state   = ST_ATYP;
        end else psr_state = ST_ERROR;
      end
      ST_ATYP: begin
        if (b == ATYP_IPV4) begin
          r.event_res = EV_ATYP;
          psr_atyp    = b[2:0];
          psr_len     = IPV4_LEN;
          psr_state   = ST_ADDR;
        end else if (b == ATYP_DOMAIN) begin
          // length register keeps its old value until the length byte
          r.event_res = EV_ATYP;
          psr_atyp    = b[2:0];
          psr_state   = ST_DOMLEN;
        end else if (b == ATYP_IPV6) begin
          r.event_res = EV_ATYP;
          psr_atyp    = b[2:0];
          psr_len     = IPV6_LEN;
          psr_state   = ST_ADDR;
        end else psr_state = ST_ERROR;
      end
      ST_DOMLEN: begin
        r.event_res = EV_DOMLEN;
        psr_len     = b;
        psr_state   = ST_ADDR;
      end
      ST_ADDR: begin
        // compare after increment: a zero length still takes one byte
        r.event_res  = EV_ADDR;
        r.addr_index = psr_cnt;
        psr_cnt      = psr_cnt + 8'd1;
        if (psr_cnt >= psr_len) begin
          r.event_res = EV_PORT_HI;
          psr_state   = ST_PORT_HI;
        end
      end
      ST_PORT_HI: begin
        r.event_res = EV_PORT_HI;
        psr_port    = {psr_port[7:0], b};
        psr_state   = ST_PORT_LO;
      end
      ST_PORT_LO: begin
        r.event_res = EV_PORT_LO;
        psr_port    = {psr_port[7:0], b};
        psr_state   = ST_DONE;
      end
      ST_DONE: r.event_res = EV_DONE;
      default: psr_state = ST_ERROR;
    endcase
    r.data_byte   = b;
    r.command     = psr_cmd;
    r.addr_type   = psr_atyp;
    r.addr_length = psr_len;
    r.dest_port   = psr_port;
    return r;
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    rx_item_t it;
    it.data  = b;
    it.drain = 1'b0;
    rx_items.push_back(it);
  endtask

  // Build the request stream, run reset, wait for the last word
  initial begin
    int         bad_at;
    int         kind;
    int         n_addr;
    logic [7:0] b;
    logic [7:0] dom_len;
    logic [15:0] port;

    // break the header in about one run out of five
    bad_at = ($urandom_range(9) < 2) ? $urandom_range(3) : 4;

    if (bad_at == 0) begin
      do b = 8'($urandom_range(255)); while (b == VERSION_BYTE);
    end else b = VERSION_BYTE;
    queue_byte(b);

    if (bad_at == 1) b = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 4));
    else b = 8'($urandom_range(CMD_UDP, CMD_CONNECT));
    queue_byte(b);

    if (bad_at == 2) b = 8'($urandom_range(255, 1));
    else b = RSV_BYTE;
    queue_byte(b);

    kind = $urandom_range(2);
    if (bad_at == 3) begin
      do b = 8'($urandom_range(255));
      while (b == ATYP_IPV4 || b == ATYP_DOMAIN || b == ATYP_IPV6);
    end else if (kind == 0) b = ATYP_IPV4;
    else if (kind == 1) b = ATYP_DOMAIN;
    else b = ATYP_IPV6;
    queue_byte(b);

    if (bad_at == 4) begin
      // address bytes, then the port
      if (kind == 0) n_addr = int'(IPV4_LEN);
      else if (kind == 2) n_addr = int'(IPV6_LEN);
      else begin
        case ($urandom_range(3))
          0:       dom_len = 8'd0;
          1:       dom_len = 8'd255;
          2:       dom_len = 8'd1;
          default: dom_len = 8'($urandom_range(254, 2));
        endcase
        queue_byte(dom_len);
        n_addr = (dom_len == 8'd0) ? 1 : int'(dom_len);
      end
      for (int i = 0; i < n_addr; i++) begin
        if (i == 0) b = 8'h00;
        else if (i == 1) b = 8'hFF;
        else b = 8'($urandom_range(255));
        queue_byte(b);
      end
      case ($urandom_range(3))
        0:       port = 16'h0000;
        1:       port = 16'hFFFF;
        default: port = 16'($urandom_range(16'hFFFF));
      endcase
      queue_byte(port[15:8]);
      queue_byte(port[7:0]);
    end

    // trailing bytes land in the sticky done or error state
    while (rx_items.size() < TARGET_ITEMS) queue_byte(8'($urandom_range(255)));

    n_items = rx_items.size();
    rx_items[4].drain = 1'b1;
    rx_items[n_items / 3].drain = 1'b1;
    rx_items[(2 * n_items) / 3].drain = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (sent_cnt == n_items && got_cnt == n_items);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && predicted_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Driver: present the next byte, hold it while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'd0;
      sent_cnt   <= 0;
      drv_idx     = 0;
    end else begin
      drv_valid = in_valid_i;
      drv_sent  = sent_cnt;
      if (in_valid_i && !in_stall_o) begin
        drv_valid = 1'b0;
        drv_sent  = sent_cnt + 1;
      end
      if (!drv_valid && drv_idx < n_items) begin
        // drain all outstanding words before a flagged byte
        if (!(rx_items[drv_idx].drain && drv_sent != got_cnt) &&
            $urandom_range(99) >= idle_pct(drv_idx, 1'b1)) begin
          drv_valid = 1'b1;
          rx_byte_i <= rx_items[drv_idx].data;
          drv_idx   = drv_idx + 1;
        end
      end
      in_valid_i <= drv_valid;
      sent_cnt   <= drv_sent;
    end
  end

  // Monitor: check accepted words, then predict the byte accepted this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      got_cnt     <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_cnt <= got_cnt + 1;
        mon_act = {event_res_o, data_byte_o, addr_index_o, command_o,
                   addr_type_o, addr_length_o, dest_port_o};
        if (predicted_words.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected word: ev=%0d data=%02h idx=%0d", event_res_o,
                     data_byte_o, addr_index_o);
        end else begin
          mon_exp = predicted_words.pop_front();
          if (mon_act !== mon_exp) begin
            mismatch_cnt = mismatch_cnt + 1;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("word %0d exp: ev=%0d data=%02h idx=%0d cmd=%0d atyp=%0d len=%0d port=%04h",
                       got_cnt, mon_exp.event_res, mon_exp.data_byte, mon_exp.addr_index,
                       mon_exp.command, mon_exp.addr_type, mon_exp.addr_length,
                       mon_exp.dest_port);
              $display("word %0d got: ev=%0d data=%02h idx=%0d cmd=%0d atyp=%0d len=%0d port=%04h",
                       got_cnt, mon_act.event_res, mon_act.data_byte, mon_act.addr_index,
                       mon_act.command, mon_act.addr_type, mon_act.addr_length,
                       mon_act.dest_port);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) predicted_words.push_back(parse_byte(rx_byte_i));
      out_stall_i <= ($urandom_range(99) < idle_pct(sent_cnt, 1'b0));
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
